FILE: rtl/mhpq_pkg.sv
package mhpq_pkg;

  // Heap geometry
  localparam int CAPACITY = 64;
  localparam int IDX_W    = $clog2(CAPACITY);
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  // child index width, wide enough for 2*pos+2 without wrapping
  localparam int CH_W     = IDX_W + 2;

  // Field widths
  localparam int VAL_W    = 32;
  localparam int STAT_W   = 2;
  localparam int OUT_RAW  = VAL_W + 1 + CNT_W + STAT_W;
  localparam int OUT_W    = ((OUT_RAW + 7) / 8) * 8;

  // Operation selector
  localparam logic ACT_PUSH = 1'b0;
  localparam logic ACT_POP  = 1'b1;

  // Status codes
  localparam logic [STAT_W-1:0] ST_OK        = 2'd0;
  localparam logic [STAT_W-1:0] ST_POP_EMPTY = 2'd1;
  localparam logic [STAT_W-1:0] ST_PUSH_FULL = 2'd2;

  // Compare unit choice: which of the three candidates is largest
  typedef enum logic [1:0] {
    SEL_BASE,
    SEL_A,
    SEL_B
  } sel_t;

endpackage

FILE: rtl/mhpq_cmp.sv
// Best of three by strict signed greater-than; a beats base first,
// then b beats the running best, so ties go to the earlier candidate.
module mhpq_cmp
  import mhpq_pkg::*;
(
  input  logic signed [VAL_W-1:0] base,
  input  logic signed [VAL_W-1:0] cand_a,
  input  logic                    cand_a_ok,
  input  logic signed [VAL_W-1:0] cand_b,
  input  logic                    cand_b_ok,
  output sel_t                    sel
);

  logic signed [VAL_W-1:0] best_ab;
  logic                    a_wins;

  always_comb begin
    a_wins  = cand_a_ok && (cand_a > base);
    best_ab = a_wins ? cand_a : base;
    if (cand_b_ok && (cand_b > best_ab)) begin
      sel = SEL_B;
    end else if (a_wins) begin
      sel = SEL_A;
    end else begin
      sel = SEL_BASE;
    end
  end

endmodule

FILE: rtl/max_heap_priority_queue.sv
// Binary max-heap priority queue of signed 32-bit values, 64 entries.
// Input channel: in_tuser selects the operation (0 push, 1 pop maximum),
// in_tdata carries the value for a push. One transaction in gives exactly
// one transaction out describing the heap after the operation: maximum
// (0 when empty), empty flag, entry count and status.
// A pop on an empty heap leaves it unchanged and reports status 1; a push
// on a full heap is dropped and reports status 2.
// A push writes its value at the end and climbs level by level while it beats
// its parent; a pop moves the last entry to the root and descends level by
// level, or ends with no descent when it empties the heap. In a 64-entry heap
// a push climbs at most 6 levels and a pop descends at most 5.
// in_tready returns as the result is registered. Each level costs one
// registered memory read (two read ports, one write port) followed by one
// pass through the shared comparator. Status-only cases go from acceptance
// straight to the done state without touching the heap store.
// One transaction in flight; in_tready is high while the sequencer is idle.
// The result sits in an output register, so the next transaction may be
// taken while the receiver stalls; the sequencer then holds its finished
// result until the output register frees up. Reset empties the heap at once.
module max_heap_priority_queue
  import mhpq_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  input  logic [VAL_W-1:0]  in_tdata,   // [31:0] value
  input  logic              in_tuser,   // [0] action
  output logic              out_tvalid,
  input  logic              out_tready,
  output logic [OUT_W-1:0]  out_tdata   // [31:0] top_value, [32] is_empty,
                                        // [39:33] entry_count, [41:40] status
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_POP_LD,
    S_UP_RD,
    S_UP_CMP,
    S_DN_RD,
    S_DN_CMP,
    S_DONE
  } state_t;

  state_t                  state_r, state_nxt;
  logic [CNT_W-1:0]        cnt_r, cnt_nxt;
  logic [IDX_W-1:0]        pos_r, pos_nxt;
  logic signed [VAL_W-1:0] val_r, val_nxt;
  logic signed [VAL_W-1:0] top_r, top_nxt;
  logic [STAT_W-1:0]       status_r, status_nxt;
  logic                    out_valid_r, out_valid_nxt;
  logic [OUT_W-1:0]        out_tdata_r, out_tdata_nxt;

  // heap store: one write port, two registered read ports
  logic signed [VAL_W-1:0] mem [CAPACITY];
  logic signed [VAL_W-1:0] rdata0_r, rdata1_r;
  logic [IDX_W-1:0]        ra0, ra1, wa;
  logic signed [VAL_W-1:0] wd;
  logic                    we;

  logic [IDX_W-1:0]        parent;
  logic [CH_W-1:0]         lc, rc;
  logic                    lc_ok, rc_ok;
  logic                    in_fire;

  // shared comparator operands
  logic signed [VAL_W-1:0] cmp_base, cmp_a, cmp_b;
  logic                    cmp_a_ok, cmp_b_ok;
  sel_t                    cmp_sel;

  assign in_tready  = (state_r == S_IDLE);
  assign in_fire    = in_tvalid && in_tready;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_tdata_r;

  // tree navigation
  assign parent = (pos_r - IDX_W'(1)) >> 1;
  assign lc     = CH_W'({pos_r, 1'b1});
  assign rc     = CH_W'({pos_r, 1'b0}) + CH_W'(2);
  assign lc_ok  = lc < CH_W'(cnt_r);
  assign rc_ok  = rc < CH_W'(cnt_r);

  // up: child value competes against its parent; down: node against children
  always_comb begin
    if (state_r == S_UP_CMP) begin
      cmp_base = rdata0_r;
      cmp_a    = val_r;
      cmp_a_ok = 1'b1;
      cmp_b    = rdata1_r;
      cmp_b_ok = 1'b0;
    end else begin
      cmp_base = val_r;
      cmp_a    = rdata0_r;
      cmp_a_ok = lc_ok;
      cmp_b    = rdata1_r;
      cmp_b_ok = rc_ok;
    end
  end

  mhpq_cmp u_cmp (
    .base      (cmp_base),
    .cand_a    (cmp_a),
    .cand_a_ok (cmp_a_ok),
    .cand_b    (cmp_b),
    .cand_b_ok (cmp_b_ok),
    .sel       (cmp_sel)
  );

  // sequencer
  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    pos_nxt       = pos_r;
    val_nxt       = val_r;
    status_nxt    = status_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_tdata_nxt = out_tdata_r;
    ra0           = lc[IDX_W-1:0];
    ra1           = rc[IDX_W-1:0];
    wa            = pos_r;
    wd            = val_r;
    we            = 1'b0;

    case (state_r)
      S_IDLE: begin
        ra0 = IDX_W'(cnt_r - CNT_W'(1));
        if (in_fire) begin
          status_nxt = ST_OK;
          if (in_tuser == ACT_PUSH) begin
            if (cnt_r == CNT_W'(CAPACITY)) begin
              status_nxt = ST_PUSH_FULL;
              state_nxt  = S_DONE;
            end else begin
              val_nxt   = in_tdata;
              pos_nxt   = cnt_r[IDX_W-1:0];
              cnt_nxt   = cnt_r + CNT_W'(1);
              state_nxt = S_UP_RD;
            end
          end else begin
            if (cnt_r == '0) begin
              status_nxt = ST_POP_EMPTY;
              state_nxt  = S_DONE;
            end else begin
              cnt_nxt   = cnt_r - CNT_W'(1);
              state_nxt = S_POP_LD;
            end
          end
        end
      end
      S_POP_LD: begin
        // last entry now in rdata0_r; it restarts from the root
        val_nxt = rdata0_r;
        pos_nxt = '0;
        if (cnt_r == '0) begin
          state_nxt = S_DONE;
        end else begin
          state_nxt = S_DN_RD;
        end
      end
      S_UP_RD: begin
        ra0 = parent;
        if (pos_r == '0) begin
          we        = 1'b1;
          state_nxt = S_DONE;
        end else begin
          state_nxt = S_UP_CMP;
        end
      end
      S_UP_CMP: begin
        we = 1'b1;
        if (cmp_sel == SEL_A) begin
          wd        = rdata0_r;
          pos_nxt   = parent;
          state_nxt = S_UP_RD;
        end else begin
          state_nxt = S_DONE;
        end
      end
      S_DN_RD: begin
        state_nxt = S_DN_CMP;
      end
      S_DN_CMP: begin
        we = 1'b1;
        case (cmp_sel)
          SEL_A: begin
            wd        = rdata0_r;
            pos_nxt   = lc[IDX_W-1:0];
            state_nxt = S_DN_RD;
          end
          SEL_B: begin
            wd        = rdata1_r;
            pos_nxt   = rc[IDX_W-1:0];
            state_nxt = S_DN_RD;
          end
          default: begin
            state_nxt = S_DONE;
          end
        endcase
      end
      S_DONE: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          out_tdata_nxt = OUT_W'({status_r, cnt_r, (cnt_r == '0),
                                  ((cnt_r == '0) ? '0 : top_r)});
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    // root copy tracks every write to the root slot
    top_nxt = (we && (wa == '0)) ? wd : top_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
    pos_r       <= pos_nxt;
    val_r       <= val_nxt;
    top_r       <= top_nxt;
    status_r    <= status_nxt;
    out_tdata_r <= out_tdata_nxt;
  end

  // heap store
  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa] <= wd;
    end
    rdata0_r <= mem[ra0];
    rdata1_r <= mem[ra1];
  end

  // checks
  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(CAPACITY))
    else $error("fill count beyond capacity");

  a_write_busy: assert property (@(posedge clk) disable iff (!rst_n)
    we |-> (state_r != S_IDLE && state_r != S_DONE))
    else $error("store written outside a sift");

  a_dn_pos: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DN_RD) |-> (CNT_W'(pos_r) < cnt_r))
    else $error("sift-down position outside heap");

  a_full_status: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DONE && status_r == ST_PUSH_FULL) |-> (cnt_r == CNT_W'(CAPACITY)))
    else $error("push-full status with room left");

  a_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && in_tuser == ACT_POP && cnt_r == '0) |=> (status_r == ST_POP_EMPTY))
    else $error("pop on empty not flagged");

endmodule

FILE: verif/max_heap_priority_queue_tb.sv
module max_heap_priority_queue_tb
  import mhpq_pkg::*;
;

  localparam int N_RANDOM    = 1750;
  localparam int QUIET_LIMIT = 3000;
  localparam int N_DIRECTED  = 24;

  // One result transaction, unpacked
  typedef struct {
    logic signed [VAL_W-1:0] top;
    logic                    empty;
    logic [CNT_W-1:0]        count;
    logic [STAT_W-1:0]       status;
  } heap_result_t;

  // Directed stimulus row; given marks a hand-written expectation
  typedef struct {
    logic         act;
    logic [31:0]  val;
    bit           given;
    heap_result_t res;
  } heap_row_t;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_tvalid = 1'b0;
  logic              in_tready;
  logic [VAL_W-1:0]  in_tdata = '0;  // [31:0] value
  logic              in_tuser = 1'b0; // [0] action
  logic              out_tvalid;
  logic              out_tready = 1'b0;
  logic [OUT_W-1:0]  out_tdata;      // [31:0] top_value, [32] is_empty,
                                     // [39:33] entry_count, [41:40] status

  // Shadow heap and the results still owed by the block
  logic signed [VAL_W-1:0] heap_model [CAPACITY];
  int                      heap_fill = 0;
  heap_result_t            pending_results [$];

  bit        failed = 1'b0;
  int        quiet_cycles = 0;
  int        ready_run = 0;
  int        ready_pick;
  heap_row_t directed_rows [N_DIRECTED];

  max_heap_priority_queue dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  always #6 clk = ~clk;

  // Apply one operation to the shadow heap and return the resulting view
  function automatic heap_result_t heap_apply(logic act, logic signed [VAL_W-1:0] val);
    heap_result_t            res;
    int                      pos;
    int                      parent;
    int                      lc;
    int                      rc;
    int                      best;
    bit                      moving;
    logic signed [VAL_W-1:0] tmp;
    res.status = ST_OK;
    if (act == ACT_PUSH) begin
      if (heap_fill >= CAPACITY) begin
        res.status = ST_PUSH_FULL;
      end else begin
        heap_model[heap_fill] = val;
        pos = heap_fill;
        heap_fill++;
        moving = 1'b1;
        // climb while strictly greater than the parent
        while (moving && pos > 0) begin
          parent = (pos - 1) / 2;
          if (heap_model[pos] > heap_model[parent]) begin
            tmp = heap_model[pos];
            heap_model[pos] = heap_model[parent];
            heap_model[parent] = tmp;
            pos = parent;
          end else begin
            moving = 1'b0;
          end
        end
      end
    end else begin
      if (heap_fill == 0) begin
        res.status = ST_POP_EMPTY;
      end else begin
        heap_fill--;
        heap_model[0] = heap_model[heap_fill];
        pos = 0;
        moving = 1'b1;
        // descend; left child wins a tie between children
        while (moving) begin
          lc = 2 * pos + 1;
          rc = 2 * pos + 2;
          best = pos;
          if (lc < heap_fill && heap_model[lc] > heap_model[best]) best = lc;
          if (rc < heap_fill && heap_model[rc] > heap_model[best]) best = rc;
          if (best == pos) begin
            moving = 1'b0;
          end else begin
            tmp = heap_model[pos];
            heap_model[pos] = heap_model[best];
            heap_model[best] = tmp;
            pos = best;
          end
        end
      end
    end
    res.top   = (heap_fill != 0) ? heap_model[0] : '0;
    res.empty = (heap_fill == 0);
    res.count = CNT_W'(heap_fill);
    return res;
  endfunction

  // Values: plenty of near-equal ones for ties, the extremes, and full-range noise
  function automatic logic [VAL_W-1:0] pick_value();
    case ($urandom_range(9))
      0, 1: pick_value = 32'($urandom_range(8)) - 32'd4;
      2: begin
        case ($urandom_range(3))
          0: pick_value = 32'h7fff_ffff;
          1: pick_value = 32'h8000_0000;
          2: pick_value = 32'h0000_0000;
          default: pick_value = 32'hffff_ffff;
        endcase
      end
      default: pick_value = $urandom;
    endcase
  endfunction

  // Mostly back-to-back or short gaps, now and then a long one
  function automatic int pick_gap(bit steady);
    int r;
    r = $urandom_range(99);
    if (steady || r < 55) pick_gap = 0;
    else if (r < 88) pick_gap = $urandom_range(3, 1);
    else pick_gap = $urandom_range(40, 6);
  endfunction

  // Drive one transaction after an optional gap; returns the predicted result
  task automatic send_op(input logic act, input logic [VAL_W-1:0] val, input int gap,
                         output heap_result_t predicted);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= act;
    in_tdata  <= val;
    do @(posedge clk); while (!in_tready);
    predicted = heap_apply(act, val);
  endtask

  // Hold the sender off until every owed result has come back
  task automatic wait_drained();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (pending_results.size() != 0);
  endtask

  // Queue one expected result behind those already owed
  task automatic owe_result(input heap_result_t res);
    pending_results = {pending_results, res};
  endtask

  task automatic send_random(input logic act, input bit steady, inout int sent);
    heap_result_t predicted;
    send_op(act, pick_value(), pick_gap(steady), predicted);
    owe_result(predicted);
    sent++;
  endtask

  // Receiver: ready and stall stretches of random length
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else if (ready_run == 0) begin
      ready_pick = $urandom_range(99);
      if (ready_pick < 15) begin
        out_tready <= 1'b1;
        ready_run  <= $urandom_range(200, 60);
      end else if (ready_pick < 60) begin
        out_tready <= 1'b1;
        ready_run  <= $urandom_range(6, 1);
      end else if (ready_pick < 92) begin
        out_tready <= 1'b0;
        ready_run  <= $urandom_range(3, 1);
      end else begin
        out_tready <= 1'b0;
        ready_run  <= $urandom_range(40, 8);
      end
    end else begin
      ready_run <= ready_run - 1;
    end
  end

  // Result checker
  always @(posedge clk) begin
    heap_result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result transaction, data %h", $time, out_tdata);
        failed = 1'b1;
      end else begin
        want = pending_results.pop_front();
        if (out_tdata[31:0] !== want.top) begin
          $display("%0t: top_value expected %0d actual %0d", $time, want.top,
                   $signed(out_tdata[31:0]));
          failed = 1'b1;
        end
        if (out_tdata[32] !== want.empty) begin
          $display("%0t: is_empty expected %b actual %b", $time, want.empty, out_tdata[32]);
          failed = 1'b1;
        end
        if (out_tdata[39:33] !== want.count) begin
          $display("%0t: entry_count expected %0d actual %0d", $time, want.count,
                   out_tdata[39:33]);
          failed = 1'b1;
        end
        if (out_tdata[41:40] !== want.status) begin
          $display("%0t: status expected %0d actual %0d", $time, want.status,
                   out_tdata[41:40]);
          failed = 1'b1;
        end
      end
    end
  end

  // Count cycles with no transaction on either side
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
  end

  initial begin : watchdog
    while (quiet_cycles < QUIET_LIMIT) @(posedge clk);
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // Stimulus
  initial begin : stimulus
    heap_result_t predicted;
    int           sent;
    int           episode;
    int           kind;
    int           len;
    bit           steady;

    directed_rows = '{
      // pop on an empty heap straight after reset
      '{ACT_POP,  32'h0000_0000, 1'b1, '{32'sd0, 1'b1, 7'd0, ST_POP_EMPTY}},
      '{ACT_PUSH, 32'h8000_0000, 1'b1, '{32'sh8000_0000, 1'b0, 7'd1, ST_OK}},
      '{ACT_PUSH, 32'h7fff_ffff, 1'b1, '{32'sh7fff_ffff, 1'b0, 7'd2, ST_OK}},
      '{ACT_PUSH, 32'h0000_0000, 1'b0, '{32'sd0, 1'b0, 7'd0, ST_OK}},
      '{ACT_PUSH, 32'hffff_ffff, 1'b0, '{32'sd0, 1'b0, 7'd0, ST_OK}},
      // equal values exercise the tie rules
      '{ACT_PUSH, 32'h0000_0005, 1'b0, '{32'sd0, 1'b0, 7'd0, ST_OK}},
      '{ACT_PUSH, 32'h0000_0005, 1'b0, '{32'sd0, 1'b0, 7'd0, ST_OK}},
      '{ACT_PUSH, 32'h7fff_ffff, 1'b1, '{32'sh7fff_ffff, 1'b0, 7'd7, ST_OK}},
      '{ACT_POP,  32'hdead_beef, 1'b1, '{32'sh7fff_ffff, 1'b0, 7'd6, ST_OK}},
      '{ACT_POP,  32'h0000_0000, 1'b0, '{32'sd0, 1'b0, 7'd0, ST_OK}},
      '{ACT_POP,  32'hffff_ffff, 1'b0, '{32'sd0, 1'b0, 7'd0, ST_OK}},
      '{ACT_POP,  32'h0000_0000, 1'b0, '{32'sd0, 1'b0, 7'd0, ST_OK}},
      '{ACT_POP,  32'h0000_0000, 1'b0, '{32'sd0, 1'b0, 7'd0, ST_OK}},
      '{ACT_POP,  32'h0000_0000, 1'b0, '{32'sd0, 1'b0, 7'd0, ST_OK}},
      // last entry leaves, empty view reports zero
      '{ACT_POP,  32'h0000_0000, 1'b1, '{32'sd0, 1'b1, 7'd0, ST_OK}},
      '{ACT_POP,  32'h7fff_ffff, 1'b1, '{32'sd0, 1'b1, 7'd0, ST_POP_EMPTY}},
      '{ACT_PUSH, 32'hffff_fffe, 1'b0, '{32'sd0, 1'b0, 7'd0, ST_OK}},
      '{ACT_PUSH, 32'hffff_fffd, 1'b0, '{32'sd0, 1'b0, 7'd0, ST_OK}},
      '{ACT_PUSH, 32'h8000_0000, 1'b0, '{32'sd0, 1'b0, 7'd0, ST_OK}},
      '{ACT_POP,  32'h0000_0000, 1'b0, '{32'sd0, 1'b0, 7'd0, ST_OK}},
      '{ACT_POP,  32'h0000_0000, 1'b0, '{32'sd0, 1'b0, 7'd0, ST_OK}},
      '{ACT_POP,  32'h0000_0000, 1'b1, '{32'sd0, 1'b1, 7'd0, ST_OK}},
      '{ACT_PUSH, 32'h0000_0001, 1'b1, '{32'sd1, 1'b0, 7'd1, ST_OK}},
      '{ACT_POP,  32'h0000_0000, 1'b1, '{32'sd0, 1'b1, 7'd0, ST_OK}}
    };

    // synchronous reset, then released
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed table
    for (int i = 0; i < N_DIRECTED; i++) begin
      send_op(directed_rows[i].act, directed_rows[i].val, pick_gap(1'b0), predicted);
      if (directed_rows[i].given) owe_result(directed_rows[i].res);
      else owe_result(predicted);
    end

    // random episodes: fill to full, drain to empty, mixed traffic, noise
    sent = 0;
    episode = 0;
    while (sent < N_RANDOM) begin
      if (episode == 1 || $urandom_range(3) == 0) wait_drained();
      steady = ($urandom_range(4) == 0);
      kind = (episode == 0) ? 0 : $urandom_range(3);
      case (kind)
        0: begin
          while (heap_fill < CAPACITY)
            send_random(($urandom_range(9) == 0) ? ACT_POP : ACT_PUSH, steady, sent);
          len = $urandom_range(4, 1);
          repeat (len) send_random(ACT_PUSH, steady, sent);
        end
        1: begin
          while (heap_fill > 0)
            send_random(($urandom_range(9) == 0) ? ACT_PUSH : ACT_POP, steady, sent);
          len = $urandom_range(3, 1);
          repeat (len) send_random(ACT_POP, steady, sent);
        end
        2: begin
          len = $urandom_range(80, 20);
          repeat (len)
            send_random(($urandom_range(99) < 52) ? ACT_PUSH : ACT_POP, steady, sent);
        end
        default: begin
          len = $urandom_range(30, 5);
          repeat (len) send_random(logic'($urandom_range(1)), steady, sent);
        end
      endcase
      episode++;
    end

    // let the last results come home, then a short tail
    wait_drained();
    repeat (30) @(posedge clk);
    if (!failed && pending_results.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

FILE: max_heap_priority_queue.f
rtl/mhpq_pkg.sv
rtl/mhpq_cmp.sv
rtl/max_heap_priority_queue.sv
verif/max_heap_priority_queue_tb.sv
